>>> hw/rtl/trs_pkg.sv
// Shared types, constants and rounding helpers for the TRS matrix block.
// No dependencies; everything else in hw/rtl imports it.
`default_nettype none

package trs_pkg;

  localparam int ANGLE_W = 16;
  localparam int SCALE_W = 24;
  localparam int POS_W   = 32;
  localparam int OUT_W   = 32;
  localparam int SIN_W   = 32;
  localparam int ENT_W   = 33;
  localparam int SPROD_W = 57;
  localparam int ANG_EXT = 24;

  // quarter-sine Horner coefficients, innermost first
  localparam logic [30:0] SIN_COEF [6] = '{
    31'd3864, 31'd172272, 31'd5026994, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  typedef struct packed {
    logic en;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [SCALE_W-1:0] scale_z;
    logic signed [POS_W-1:0]   position_x;
    logic signed [POS_W-1:0]   position_y;
    logic signed [POS_W-1:0]   position_z;
  } pass_t;

  // shift right by 30, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] v);
    logic signed [63:0] adj;
    adj = v + 64'sd536870912 - {63'b0, v[63]};
    return adj >>> 30;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/trs_in_if.sv
// Input channel: Euler angles, scale and position, valid/ready handshake.
// Depends on trs_pkg.
`default_nettype none

interface trs_in_if import trs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ANGLE_W-1:0]        pitch_angle;
  logic [ANGLE_W-1:0]        yaw_angle;
  logic [ANGLE_W-1:0]        roll_angle;
  logic signed [SCALE_W-1:0] scale_x;
  logic signed [SCALE_W-1:0] scale_y;
  logic signed [SCALE_W-1:0] scale_z;
  logic signed [POS_W-1:0]   position_x;
  logic signed [POS_W-1:0]   position_y;
  logic signed [POS_W-1:0]   position_z;

  modport source (output valid, pitch_angle, yaw_angle, roll_angle, scale_x, scale_y,
                  scale_z, position_x, position_y, position_z, input ready);
  modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, scale_x, scale_y,
                  scale_z, position_x, position_y, position_z, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/trs_out_if.sv
// Output channel: top three rows of the transform matrix, valid/ready handshake.
// Depends on trs_pkg.
`default_nettype none

interface trs_out_if import trs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] row0_col0, row0_col1, row0_col2, row0_col3;
  logic signed [OUT_W-1:0] row1_col0, row1_col1, row1_col2, row1_col3;
  logic signed [OUT_W-1:0] row2_col0, row2_col1, row2_col2, row2_col3;

  modport source (output valid, row0_col0, row0_col1, row0_col2, row0_col3,
                  row1_col0, row1_col1, row1_col2, row1_col3,
                  row2_col0, row2_col1, row2_col2, row2_col3, input ready);
  modport sink   (input valid, row0_col0, row0_col1, row0_col2, row0_col3,
                  row1_col0, row1_col1, row1_col2, row1_col3,
                  row2_col0, row2_col1, row2_col2, row2_col3, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/trs_sin.sv
// Pipelined fixed-point sine/cosine, Q1.30 out, eight register stages.
// Depends on trs_pkg.
`default_nettype none

module trs_sin import trs_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire pipe_ctl_t               ctl_i,
  input  wire logic [ANGLE_BITS-1:0]   angle_i,
  input  wire logic                    cos_i,
  output      logic signed [SIN_W-1:0] sin_o
);

  localparam int FB = ANGLE_BITS - 2;

  logic [1:0]  quad;
  logic [29:0] tf, t_in;
  logic        full_in;

  // cosine is the sine one quadrant on
  assign quad    = angle_i[ANGLE_BITS-1 -: 2] + {1'b0, cos_i};
  assign tf      = 30'(angle_i[FB-1:0]) << (32 - ANGLE_BITS);
  assign t_in    = quad[0] ? (~tf + 30'd1) : tf;
  assign full_in = quad[0] & (tf == 30'd0);

  logic [29:0] t_q    [1:6];
  logic [29:0] u_q    [2:5];
  logic        neg_q  [1:7];
  logic        full_q [1:7];
  logic [61:0] m_q    [1:7];
  logic [30:0] p_d    [3:7];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      t_q[1]    <= t_in;
      neg_q[1]  <= quad[1];
      full_q[1] <= full_in;
      m_q[1]    <= 62'(t_in) * 62'(t_in);
      u_q[2]    <= m_q[1][59:30];
      m_q[2]    <= 62'(m_q[1][59:30]) * 62'(SIN_COEF[0]);
    end
  end

  for (genvar s = 2; s <= 7; s++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        neg_q[s]  <= neg_q[s-1];
        full_q[s] <= full_q[s-1];
      end
    end
  end

  for (genvar s = 2; s <= 6; s++) begin : g_t
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) t_q[s] <= t_q[s-1];
    end
  end

  // Horner steps: coefficient minus previous term, times u
  for (genvar s = 3; s <= 6; s++) begin : g_horner
    assign p_d[s] = SIN_COEF[s-2] - m_q[s-1][60:30];
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) m_q[s] <= 62'(u_q[s-1]) * 62'(p_d[s]);
    end
    if (s < 6) begin : g_u
      always_ff @(posedge clk_i) begin
        if (ctl_i.en) u_q[s] <= u_q[s-1];
      end
    end
  end

  assign p_d[7] = SIN_COEF[5] - m_q[6][60:30];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) m_q[7] <= 62'(t_q[6]) * 62'(p_d[7]);
  end

  logic [31:0] pr, mag;
  assign pr  = m_q[7][61:30];
  assign mag = (full_q[7] || pr > 32'd1073741824) ? 32'd1073741824 : pr;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) sin_o <= neg_q[7] ? -$signed(mag) : $signed(mag);
  end

endmodule

`default_nettype wire

>>> hw/rtl/trs_matrix_from_euler.sv
// TRS transform matrix from Euler angles: one word per cycle when not stalled.
// Stages 1-8 are the sine/cosine units, 9-11 the rotation products and sums,
// 12 the scale multiply, 13 rounding, saturation and the output register.
// All stages advance together whenever the output register is empty or taken.
// Reset (rst_ni low, asynchronous) clears the valid bits only.
`default_nettype none

module trs_matrix_from_euler import trs_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  trs_in_if.sink   in_i,
  trs_out_if.source out_o
);

  localparam int NSTG = 13;

  // ---- pipeline control ----
  logic            en;
  logic [NSTG:1]   vld_q;
  pipe_ctl_t       ctl;

  assign en          = ~vld_q[NSTG] | out_o.ready;
  assign ctl.en      = en;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-1:1], in_i.valid};
    end
  end

  // ---- angles: unused high bits dropped ----
  logic [ANG_EXT-1:0] pa, ya, ra;
  assign pa = ANG_EXT'(in_i.pitch_angle);
  assign ya = ANG_EXT'(in_i.yaw_angle);
  assign ra = ANG_EXT'(in_i.roll_angle);

  logic signed [SIN_W-1:0] sp, cp, sy, cy, sr, cr;

  trs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sp (
    .clk_i, .ctl_i(ctl), .angle_i(pa[ANGLE_BITS-1:0]), .cos_i(1'b0), .sin_o(sp));
  trs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cp (
    .clk_i, .ctl_i(ctl), .angle_i(pa[ANGLE_BITS-1:0]), .cos_i(1'b1), .sin_o(cp));
  trs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sy (
    .clk_i, .ctl_i(ctl), .angle_i(ya[ANGLE_BITS-1:0]), .cos_i(1'b0), .sin_o(sy));
  trs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cy (
    .clk_i, .ctl_i(ctl), .angle_i(ya[ANGLE_BITS-1:0]), .cos_i(1'b1), .sin_o(cy));
  trs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sr (
    .clk_i, .ctl_i(ctl), .angle_i(ra[ANGLE_BITS-1:0]), .cos_i(1'b0), .sin_o(sr));
  trs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cr (
    .clk_i, .ctl_i(ctl), .angle_i(ra[ANGLE_BITS-1:0]), .cos_i(1'b1), .sin_o(cr));

  // ---- scale and position ride alongside ----
  pass_t pass_d;
  pass_t pass_q [1:12];

  assign pass_d = '{scale_x: in_i.scale_x, scale_y: in_i.scale_y, scale_z: in_i.scale_z,
                    position_x: in_i.position_x, position_y: in_i.position_y,
                    position_z: in_i.position_z};

  always_ff @(posedge clk_i) begin
    if (en) pass_q[1] <= pass_d;
  end

  for (genvar s = 2; s <= 12; s++) begin : g_pass
    always_ff @(posedge clk_i) begin
      if (en) pass_q[s] <= pass_q[s-1];
    end
  end

  // ---- stage 9: pairwise Q30 products ----
  logic signed [63:0] crcy_q, srsp_q, crsp_q, srcp_q, crcp_q;
  logic signed [63:0] cpsy_q, crsy_q, srcy_q, srsy_q, cpcy_q;
  logic signed [SIN_W-1:0] sy9_q, cy9_q, sp9_q, sp10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      crcy_q <= cr * cy;
      srsp_q <= sr * sp;
      crsp_q <= cr * sp;
      srcp_q <= sr * cp;
      crcp_q <= cr * cp;
      cpsy_q <= cp * sy;
      crsy_q <= cr * sy;
      srcy_q <= sr * cy;
      srsy_q <= sr * sy;
      cpcy_q <= cp * cy;
      sy9_q  <= sy;
      cy9_q  <= cy;
      sp9_q  <= sp;
    end
  end

  // ---- stage 10: round pairs, form the triple products ----
  logic signed [SIN_W-1:0] srsp_r, crsp_r;
  logic signed [SIN_W-1:0] crcy10_q, srcp10_q, crcp10_q, cpsy10_q;
  logic signed [SIN_W-1:0] crsy10_q, srcy10_q, srsy10_q, cpcy10_q;
  logic signed [63:0]      srspsy_q, srspcy_q, crspsy_q, crspcy_q;

  assign srsp_r = SIN_W'(rnd_q30(srsp_q));
  assign crsp_r = SIN_W'(rnd_q30(crsp_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      crcy10_q <= SIN_W'(rnd_q30(crcy_q));
      srcp10_q <= SIN_W'(rnd_q30(srcp_q));
      crcp10_q <= SIN_W'(rnd_q30(crcp_q));
      cpsy10_q <= SIN_W'(rnd_q30(cpsy_q));
      crsy10_q <= SIN_W'(rnd_q30(crsy_q));
      srcy10_q <= SIN_W'(rnd_q30(srcy_q));
      srsy10_q <= SIN_W'(rnd_q30(srsy_q));
      cpcy10_q <= SIN_W'(rnd_q30(cpcy_q));
      srspsy_q <= srsp_r * sy9_q;
      srspcy_q <= srsp_r * cy9_q;
      crspsy_q <= crsp_r * sy9_q;
      crspcy_q <= crsp_r * cy9_q;
      sp10_q   <= sp9_q;
    end
  end

  // ---- stage 11: rotation entries, row-major ----
  logic signed [ENT_W-1:0] ent_d [9];
  logic signed [ENT_W-1:0] ent_q [9];

  assign ent_d[0] = ENT_W'(crcy10_q) - ENT_W'(rnd_q30(srspsy_q));
  assign ent_d[1] = -ENT_W'(srcp10_q);
  assign ent_d[2] = ENT_W'(crsy10_q) + ENT_W'(rnd_q30(srspcy_q));
  assign ent_d[3] = ENT_W'(srcy10_q) + ENT_W'(rnd_q30(crspsy_q));
  assign ent_d[4] = ENT_W'(crcp10_q);
  assign ent_d[5] = ENT_W'(srsy10_q) - ENT_W'(rnd_q30(crspcy_q));
  assign ent_d[6] = -ENT_W'(cpsy10_q);
  assign ent_d[7] = ENT_W'(sp10_q);
  assign ent_d[8] = ENT_W'(cpcy10_q);

  always_ff @(posedge clk_i) begin
    if (en) ent_q <= ent_d;
  end

  // ---- stage 12: column scale ----
  logic signed [SPROD_W-1:0] sprod_q [9];

  for (genvar i = 0; i < 9; i++) begin : g_scale
    logic signed [SCALE_W-1:0] k;
    assign k = (i % 3 == 0) ? pass_q[11].scale_x :
               (i % 3 == 1) ? pass_q[11].scale_y : pass_q[11].scale_z;
    always_ff @(posedge clk_i) begin
      if (en) sprod_q[i] <= ent_q[i] * k;
    end
  end

  // ---- stage 13: Q46 -> Q16.16, saturate, output register ----
  logic signed [OUT_W-1:0] res_q [9];
  pass_t                   pos_q;

  for (genvar i = 0; i < 9; i++) begin : g_res
    always_ff @(posedge clk_i) begin
      if (en) res_q[i] <= sat32(rnd_q30(64'(sprod_q[i])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) pos_q <= pass_q[12];
  end

  assign out_o.row0_col0 = res_q[0];
  assign out_o.row0_col1 = res_q[1];
  assign out_o.row0_col2 = res_q[2];
  assign out_o.row0_col3 = pos_q.position_x;
  assign out_o.row1_col0 = res_q[3];
  assign out_o.row1_col1 = res_q[4];
  assign out_o.row1_col2 = res_q[5];
  assign out_o.row1_col3 = pos_q.position_y;
  assign out_o.row2_col0 = res_q[6];
  assign out_o.row2_col1 = res_q[7];
  assign out_o.row2_col2 = res_q[8];
  assign out_o.row2_col3 = pos_q.position_z;

  // ---- checks ----
  // a stall freezes every valid bit
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  // output word appears only after the pipeline advanced
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(en))
    else $error("output valid rose without an advance");

  // pitch sine and yaw cosine results stay within one in Q30
  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> (sp <= 32'sd1073741824 && sp >= -32'sd1073741824 &&
                  cy <= 32'sd1073741824 && cy >= -32'sd1073741824))
    else $error("sine out of range");

endmodule

`default_nettype wire
